>>> rtl/lsc_pkg.sv
// Package for the light sensor conditioner: field widths, calibration
// constants, register indexes and the reciprocal used for the calibration divide.
// No dependencies.
package lsc_pkg;

  // Converter and field widths
  localparam int ADC_BITS    = 10;
  localparam int THR_BITS    = 10;
  localparam int WEIGHT_BITS = 9;
  localparam int LUX_BITS    = 9;
  localparam int SMOOTH_BITS = 17;
  localparam int CFG_DATA_BITS  = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CMP_BITS = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;

  // Calibration points: 90 -> 10 lux, 680 -> 300 lux
  localparam int CAL_X_LO = 90;
  localparam int CAL_X_HI = 680;
  localparam int CAL_Y_LO = 10;
  localparam int CAL_Y_HI = 300;
  localparam int CAL_GAIN = CAL_Y_HI - CAL_Y_LO;   // 290, below 2**9
  localparam int CAL_DEN  = CAL_X_HI - CAL_X_LO;   // 590, below 2**10

  // |x - 90| * 290 needs ADC_BITS + 9 bits
  localparam int MAG_BITS    = ADC_BITS + 9;
  // Exact floor division by CAL_DEN for any magnitude below 2**MAG_BITS
  localparam int RECIP_SHIFT = MAG_BITS + 10;
  localparam int RECIP_BITS  = RECIP_SHIFT - 9;
  localparam logic [RECIP_BITS-1:0] RECIP_MUL =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(CAL_DEN) - 64'd1) / 64'(CAL_DEN));
  localparam int QUO_BITS    = MAG_BITS + RECIP_BITS - RECIP_SHIFT;

  // Averaging arithmetic
  localparam int ACC_BITS = WEIGHT_BITS + SMOOTH_BITS + 1;
  localparam logic [WEIGHT_BITS-1:0] ONE_Q8 = WEIGHT_BITS'(256);
  localparam int ROUND_HALF = 128;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAMP_ON_BELOW    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAMP_OFF_ABOVE   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING_WEIGHT = 2'd2;

  // Register reset values
  localparam logic [THR_BITS-1:0]    LAMP_ON_BELOW_RST    = THR_BITS'(300);
  localparam logic [THR_BITS-1:0]    LAMP_OFF_ABOVE_RST   = THR_BITS'(350);
  localparam logic [WEIGHT_BITS-1:0] SMOOTHING_WEIGHT_RST = WEIGHT_BITS'(102);

endpackage

>>> rtl/light_sensor_conditioner.sv
// Light sensor conditioner top level: calibration map, moving average and
// lamp hysteresis in a short pipeline. Depends on lsc_pkg.
//
// Usage
//   Input channel in_valid/in_ready carries one adc_sample per item.
//   Output channel out_valid/out_ready carries lamp_on, calibrated_lux and
//   smoothed_lux_q8 for every item, in order.
//   Configuration: cfg_write with cfg_index/cfg_data writes a threshold or
//   the averaging weight at once; write only while no item is in flight.
// Timing
//   Pipeline: an accepted item passes the input register, gain multiply,
//   reciprocal divide and then the average before its result is shown.
//   Throughput: one item per cycle while out_ready is high; the average and
//   lamp state close their feedback in the last stage.
// Reset
//   Clears the pipeline valids, the average to zero, the lamp to off and the
//   registers to 300, 350 and 102.
// Stall
//   When out_ready is low the result holds; earlier stages keep filling
//   their empty slots, and in_ready falls only once every stage is full.
module light_sensor_conditioner
  import lsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ADC_BITS-1:0]       adc_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      lamp_on,
  output logic [LUX_BITS-1:0]       calibrated_lux,
  output logic [SMOOTH_BITS-1:0]    smoothed_lux_q8,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers
  logic [THR_BITS-1:0]    lamp_on_below;
  logic [THR_BITS-1:0]    lamp_off_above;
  logic [WEIGHT_BITS-1:0] smoothing_weight;

  // Pipeline registers
  logic                   v1, v2, v3;
  logic [ADC_BITS-1:0]    x1, x2, x3;
  logic [MAG_BITS-1:0]    mag2;
  logic                   neg2;
  logic [LUX_BITS-1:0]    lux3;

  // State, also driving the outputs
  logic                   lamp_state;
  logic [SMOOTH_BITS-1:0] smoothed_value;
  logic [LUX_BITS-1:0]    lux_out;

  // Stage enables
  logic en_out, en3, en2;

  // Combinational values
  logic                              neg_d;
  logic [ADC_BITS-1:0]               mag_d;
  logic [MAG_BITS-1:0]               mag2_next;
  logic [MAG_BITS+RECIP_BITS-1:0]    recip_prod;
  logic [QUO_BITS-1:0]               quo;
  logic [LUX_BITS-1:0]               lux3_next;
  logic [WEIGHT_BITS-1:0]            w_sat, w_inv;
  logic [SMOOTH_BITS-1:0]            target;
  logic [ACC_BITS-1:0]               acc;
  logic [SMOOTH_BITS-1:0]            smoothed_next;
  logic                              lamp_next;
  logic [CMP_BITS-1:0]               x_cmp, on_cmp, off_cmp;

  assign en_out   = !out_valid || out_ready;
  assign en3      = !v3 || en_out;
  assign en2      = !v2 || en3;
  assign in_ready = !v1 || en2;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_on_below    <= LAMP_ON_BELOW_RST;
      lamp_off_above   <= LAMP_OFF_ABOVE_RST;
      smoothing_weight <= SMOOTHING_WEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LAMP_ON_BELOW:    lamp_on_below    <= cfg_data[THR_BITS-1:0];
        REG_LAMP_OFF_ABOVE:   lamp_off_above   <= cfg_data[THR_BITS-1:0];
        REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1 -> 2: offset from the dark point and gain
  always_comb begin
    neg_d     = x1 < ADC_BITS'(CAL_X_LO);
    mag_d     = neg_d ? (ADC_BITS'(CAL_X_LO) - x1) : (x1 - ADC_BITS'(CAL_X_LO));
    mag2_next = MAG_BITS'(mag_d) * MAG_BITS'(CAL_GAIN);
  end

  // Stage 2 -> 3: divide by the span (truncated toward zero), offset, clamp
  always_comb begin
    recip_prod = (MAG_BITS+RECIP_BITS)'(mag2) * (MAG_BITS+RECIP_BITS)'(RECIP_MUL);
    quo        = recip_prod[MAG_BITS+RECIP_BITS-1:RECIP_SHIFT];
    if (neg2) begin
      lux3_next = (quo > QUO_BITS'(CAL_Y_LO)) ? '0
                                              : LUX_BITS'(QUO_BITS'(CAL_Y_LO) - quo);
    end else begin
      lux3_next = LUX_BITS'((QUO_BITS+1)'(quo) + (QUO_BITS+1)'(CAL_Y_LO));
    end
  end

  // Stage 3 -> output: moving average and lamp hysteresis
  always_comb begin
    w_sat  = (smoothing_weight > ONE_Q8) ? ONE_Q8 : smoothing_weight;
    w_inv  = ONE_Q8 - w_sat;
    target = {SMOOTH_BITS'(lux3)} << 8;
    acc    = ACC_BITS'(w_sat) * ACC_BITS'(target)
           + ACC_BITS'(w_inv) * ACC_BITS'(smoothed_value)
           + ACC_BITS'(ROUND_HALF);
    smoothed_next = (smoothed_value == '0) ? target : acc[SMOOTH_BITS+7:8];

    x_cmp   = CMP_BITS'(x3);
    on_cmp  = CMP_BITS'(lamp_on_below);
    off_cmp = CMP_BITS'(lamp_off_above);
    lamp_next = lamp_state;
    priority if (!lamp_state && (x_cmp < on_cmp)) begin
      lamp_next = 1'b1;
    end else if (lamp_state && (x_cmp > off_cmp)) begin
      lamp_next = 1'b0;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (en2)      v2 <= v1;
      if (en3)      v3 <= v2;
      if (en_out)   out_valid <= v3;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x1 <= adc_sample;
    end
    if (en2 && v1) begin
      x2   <= x1;
      mag2 <= mag2_next;
      neg2 <= neg_d;
    end
    if (en3 && v2) begin
      x3   <= x2;
      lux3 <= lux3_next;
    end
    if (en_out && v3) begin
      lux_out <= lux3;
    end
  end

  // Feedback state, updated as each item enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_state     <= 1'b0;
      smoothed_value <= '0;
    end else if (en_out && v3) begin
      lamp_state     <= lamp_next;
      smoothed_value <= smoothed_next;
    end
  end

  assign lamp_on         = lamp_state;
  assign calibrated_lux  = lux_out;
  assign smoothed_lux_q8 = smoothed_value;

endmodule

>>> rtl/lsc_checker.sv
// Port-level checks for the light sensor conditioner, bound to the top level.
// Depends on lsc_pkg and light_sensor_conditioner.
module lsc_checker
  import lsc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      lamp_on,
  input logic [LUX_BITS-1:0]       calibrated_lux,
  input logic [SMOOTH_BITS-1:0]    smoothed_lux_q8
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no result waiting");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(lamp_on) && $stable(calibrated_lux)
       && $stable(smoothed_lux_q8)))
    else $error("stalled result changed");

  // The average only moves when a new item is shown
  a_avg_moves_with_item: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(smoothed_lux_q8)) |-> out_valid)
    else $error("average changed without a result");

  // A zero average can only follow a zero lux item
  a_zero_avg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (smoothed_lux_q8 == '0)) |-> (calibrated_lux == '0))
    else $error("zero average with non-zero lux");

endmodule

bind light_sensor_conditioner lsc_checker u_lsc_checker (.*);

>>> tb/light_sensor_conditioner_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for light_sensor_conditioner: calibration map, moving
// average and lamp hysteresis checked item by item against a local predictor.
// Depends on lsc_pkg and the light_sensor_conditioner RTL.
module light_sensor_conditioner_tb
  import lsc_pkg::*;
;

  // Register index that decodes to nothing
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int SEGMENT_ITEMS = 100;
  localparam int PHASE_ITEMS   = 600;

  typedef struct {
    logic                   lamp;
    logic [LUX_BITS-1:0]    lux;
    logic [SMOOTH_BITS-1:0] smooth;
  } lux_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [ADC_BITS-1:0]       adc_sample;
  logic                      out_valid;
  logic                      out_ready;
  logic                      lamp_on;
  logic [LUX_BITS-1:0]       calibrated_lux;
  logic [SMOOTH_BITS-1:0]    smoothed_lux_q8;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Predictor state and its copy of the registers
  logic                   lamp_lit;
  logic [SMOOTH_BITS-1:0] avg_q8;
  logic [THR_BITS-1:0]    thr_on;
  logic [THR_BITS-1:0]    thr_off;
  logic [WEIGHT_BITS-1:0] avg_weight;

  lux_result_t pending_results[$];
  int          error_count;
  int          tx_idle_pct;
  int          rx_idle_pct;

  light_sensor_conditioner dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .lamp_on        (lamp_on),
    .calibrated_lux (calibrated_lux),
    .smoothed_lux_q8(smoothed_lux_q8),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    adc_sample  = '0;
    out_ready   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    error_count = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
  end

  // Run limit
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (!rst) out_ready = ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // Linear map through the two calibration points, truncating toward zero
  function automatic logic [LUX_BITS-1:0] map_to_lux(input logic [ADC_BITS-1:0] x);
    int prod;
    int v;
    prod = (int'(x) - CAL_X_LO) * CAL_GAIN;
    v = prod / CAL_DEN + CAL_Y_LO;
    if (v < 0) v = 0;
    return v[LUX_BITS-1:0];
  endfunction

  // Advance the predictor by one sample and return the result it implies
  function automatic lux_result_t predict_lux_result(input logic [ADC_BITS-1:0] x);
    lux_result_t r;
    longint target;
    longint w;
    longint acc;
    r.lux  = map_to_lux(x);
    target = longint'(r.lux) << 8;
    w      = (avg_weight > ONE_Q8) ? longint'(ONE_Q8) : longint'(avg_weight);
    if (avg_q8 == '0) begin
      avg_q8 = target[SMOOTH_BITS-1:0];
    end else begin
      acc    = w * target + (longint'(ONE_Q8) - w) * longint'(avg_q8) + ROUND_HALF;
      avg_q8 = acc[SMOOTH_BITS+7:8];
    end
    if (!lamp_lit && x < thr_on) lamp_lit = 1'b1;
    else if (lamp_lit && x > thr_off) lamp_lit = 1'b0;
    r.lamp   = lamp_lit;
    r.smooth = avg_q8;
    return r;
  endfunction

  // Monitor: check results, predict accepted items, track register writes
  always @(posedge clk) begin
    lux_result_t want;
    if (rst) begin
      lamp_lit   = 1'b0;
      avg_q8     = '0;
      thr_on     = LAMP_ON_BELOW_RST;
      thr_off    = LAMP_OFF_ABOVE_RST;
      avg_weight = SMOOTHING_WEIGHT_RST;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no item outstanding (lux %0d)",
                                    calibrated_lux));
        end else begin
          want = pending_results.pop_front();
          if (lamp_on !== want.lamp)
            report_mismatch($sformatf("lamp_on got %b expected %b", lamp_on, want.lamp));
          if (calibrated_lux !== want.lux)
            report_mismatch($sformatf("calibrated_lux got %0d expected %0d",
                                      calibrated_lux, want.lux));
          if (smoothed_lux_q8 !== want.smooth)
            report_mismatch($sformatf("smoothed_lux_q8 got %0d expected %0d",
                                      smoothed_lux_q8, want.smooth));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(predict_lux_result(adc_sample));
      if (cfg_write) begin
        case (cfg_index)
          REG_LAMP_ON_BELOW:    thr_on     = cfg_data[THR_BITS-1:0];
          REG_LAMP_OFF_ABOVE:   thr_off    = cfg_data[THR_BITS-1:0];
          REG_SMOOTHING_WEIGHT: avg_weight = cfg_data[WEIGHT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Present one item and hold it until accepted; valid is left high
  task automatic send_sample(input logic [ADC_BITS-1:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    adc_sample = sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and let every outstanding result come out
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_for_results();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Mostly uniform, with bias toward thresholds, calibration corners and dark levels
  function automatic logic [ADC_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      6: v = int'(thr_on) + int'($urandom_range(6)) - 3;
      7: v = int'(thr_off) + int'($urandom_range(6)) - 3;
      8: begin
        case ($urandom_range(6))
          0: v = 0;
          1: v = 69;
          2: v = 70;
          3: v = 89;
          4: v = CAL_X_LO;
          5: v = CAL_X_HI;
          default: v = (1 << ADC_BITS) - 1;
        endcase
      end
      9: v = $urandom_range(69);
      default: v = $urandom_range((1 << ADC_BITS) - 1);
    endcase
    if (v < 0) v = 0;
    if (v > (1 << ADC_BITS) - 1) v = (1 << ADC_BITS) - 1;
    return v[ADC_BITS-1:0];
  endfunction

  // New thresholds and weight, extremes included
  task automatic randomize_config();
    logic [CFG_DATA_BITS-1:0] on_lvl;
    logic [CFG_DATA_BITS-1:0] off_lvl;
    logic [CFG_DATA_BITS-1:0] wgt;
    on_lvl  = CFG_DATA_BITS'($urandom_range(1023));
    off_lvl = CFG_DATA_BITS'($urandom_range(1023));
    case ($urandom_range(4))
      0: begin
        on_lvl  = '0;
        off_lvl = '1;
      end
      1: begin
        on_lvl  = '1;
        off_lvl = '0;
      end
      2: off_lvl = (on_lvl > 1000) ? on_lvl
                                   : CFG_DATA_BITS'(on_lvl + $urandom_range(20));
      3: off_lvl = on_lvl;
      default: ;
    endcase
    case ($urandom_range(5))
      0: wgt = '0;
      1: wgt = 10'd256;
      2: wgt = CFG_DATA_BITS'($urandom_range(257, 1023));
      3: wgt = 10'd1;
      default: wgt = CFG_DATA_BITS'($urandom_range(1, 255));
    endcase
    write_reg(REG_LAMP_ON_BELOW, on_lvl);
    write_reg(REG_LAMP_OFF_ABOVE, off_lvl);
    write_reg(REG_SMOOTHING_WEIGHT, wgt);
  endtask

  // Corners of the calibration map, dark band and all-ones/all-zeros samples
  task automatic test_calibration_points();
    send_sample(10'd0);
    send_sample(10'd69);
    send_sample(10'd70);
    send_sample(10'd89);
    send_sample(10'd90);
    send_sample(10'd91);
    send_sample(10'd680);
    send_sample(10'd681);
    send_sample(10'd1023);
    send_sample(10'h2AA);
    send_sample(10'h155);
  endtask

  // Lamp thresholds are strict: equal levels leave the lamp as it was
  task automatic test_lamp_hysteresis();
    wait_for_results();
    send_sample(10'd300);
    send_sample(10'd299);
    send_sample(10'd350);
    send_sample(10'd351);
  endtask

  // Full weight drives the average to zero, then a stored zero loads directly;
  // zero weight freezes it; over-range weight saturates to one
  task automatic test_weight_extremes();
    write_reg(REG_SMOOTHING_WEIGHT, 10'd256);
    send_sample(10'd69);
    send_sample(10'd680);
    write_reg(REG_SMOOTHING_WEIGHT, 10'd0);
    send_sample(10'd1023);
    write_reg(REG_SMOOTHING_WEIGHT, 10'h3FF);
    send_sample(10'd500);
  endtask

  // A write to the spare index must change nothing
  task automatic test_unknown_register();
    write_reg(REG_UNUSED, 10'h3FF);
    send_sample(10'd200);
    send_sample(10'd800);
    write_reg(REG_LAMP_ON_BELOW, 10'(LAMP_ON_BELOW_RST));
    write_reg(REG_LAMP_OFF_ABOVE, 10'(LAMP_OFF_ABOVE_RST));
    write_reg(REG_SMOOTHING_WEIGHT, 10'(SMOOTHING_WEIGHT_RST));
  endtask

  // Random items in segments, each under a fresh register setting
  task automatic test_random_phase(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int seg = 0; seg < PHASE_ITEMS / SEGMENT_ITEMS; seg++) begin
      randomize_config();
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        // sender holds off until the pipeline has drained
        if (seg % 3 == 1 && k == SEGMENT_ITEMS / 2) wait_for_results();
        send_sample(pick_sample());
      end
    end
  endtask

  // Test sequence
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_calibration_points();
    test_lamp_hysteresis();
    test_weight_extremes();
    test_unknown_register();
    test_random_phase(36, 87);
    test_random_phase(87, 36);
    test_random_phase(0, 0);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
